@@ design/ott_pkg.sv @@
// ----------------------------------------------------------------------------
// Ordered timer table package
// Operation and status codes used by the table, its checker and its testbench,
// and the controller states of the table.
// ----------------------------------------------------------------------------
package ott_pkg;

    // Request operation codes.
    typedef enum logic [1:0] {
        OP_REGISTER   = 2'd0,
        OP_UNREGISTER = 2'd1,
        OP_NEXT_WAIT  = 2'd2,
        OP_TAKE_EXP   = 2'd3
    } op_t;

    // Response status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_NO_ID     = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_ID_RD,
        S_ID_CHK,
        S_POS_RD,
        S_POS_DAT,
        S_POS_EVAL,
        S_INS_RD,
        S_INS_WR,
        S_INS_PUT,
        S_UNR_RD,
        S_UNR_CHK,
        S_DEL_RD,
        S_DEL_WR,
        S_NW_RD,
        S_NW_DAT,
        S_NW_EVAL,
        S_EXP_RD,
        S_EXP_DAT,
        S_EXP_EVAL,
        S_DONE
    } state_t;

    localparam int unsigned NOW_W     = 64;
    localparam int unsigned TIMEOUT_W = 32;
    localparam int unsigned REQ_ID_W  = 16;

endpackage

@@ design/ott_if.sv @@
// ----------------------------------------------------------------------------
// Ordered timer table channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ott_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [63:0] now_ms;
    logic [31:0] timeout_ms;
    logic [15:0] request_id;

    modport source (output valid, output operation, output now_ms, output timeout_ms,
                    output request_id, input ready);
    modport sink   (input valid, input operation, input now_ms, input timeout_ms,
                    input request_id, output ready);
endinterface

interface ott_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] timer_id;
    logic [31:0] wait_ms;

    modport source (output valid, output status, output timer_id, output wait_ms,
                    input ready);
    modport sink   (input valid, input status, input timer_id, input wait_ms,
                    output ready);
endinterface

@@ design/ordered_timer_table.sv @@
// ----------------------------------------------------------------------------
// Ordered timer table
// One-shot timers kept in expiry order in a one-read, one-write entry memory.
// ----------------------------------------------------------------------------
// One request beat is taken at a time and answered by exactly one response
// beat. Entries live in one memory with a registered read, so every pass over
// the table walks it one entry at a time. A register probes id candidates with
// a pass over the table each, passes entries to find the insert point, shifts
// the entries behind it down, then places the entry and hands over the result;
// unregister and take-expired scan for their entry and shift the tail up;
// next-wait walks the whole table. The response sits in an output register, so
// a new request is taken while it waits. No clearing pass is needed after reset.
module ordered_timer_table #(
    parameter int unsigned MAX_TIMERS = 512,
    parameter int unsigned ID_BITS    = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    ott_req_if.sink    req,
    ott_rsp_if.source  rsp
);

    localparam int unsigned AW   = $clog2(MAX_TIMERS);
    localparam int unsigned CW   = $clog2(MAX_TIMERS + 1);
    localparam int unsigned TW   = ott_pkg::TIMEOUT_W;
    localparam int unsigned NW   = ott_pkg::NOW_W;
    localparam int unsigned RW   = ott_pkg::REQ_ID_W;
    localparam int unsigned EW   = ID_BITS + TW + NW;
    localparam int unsigned CMPW = (ID_BITS > RW) ? ID_BITS : RW;
    localparam logic [ID_BITS-1:0] ID_MASK = {ID_BITS{1'b1}};
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TIMERS);

    // Entry memory: {id, timeout, start}.
    logic [EW-1:0] mem [MAX_TIMERS];
    logic [EW-1:0] rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;

    logic [ID_BITS-1:0] ent_id;
    logic [TW-1:0]      ent_to;
    logic [NW-1:0]      ent_start;

    ott_pkg::state_t state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [ID_BITS-1:0] last_reg, last_next;
    logic [CW-1:0]      k_reg, k_next;
    logic [CW-1:0]      pos_reg, pos_next;
    logic [ID_BITS-1:0] cand_reg, cand_next;
    logic [ID_BITS-1:0] tries_reg, tries_next;
    logic [NW-1:0]      el_reg, el_next;
    logic [TW-1:0]      t_reg, t_next;
    logic [NW-1:0]      now_reg, now_next;
    logic [TW-1:0]      to_reg, to_next;
    logic [RW-1:0]      rid_reg, rid_next;
    ott_pkg::status_t   st_reg, st_next;
    logic [RW-1:0]      id_reg, id_next;
    logic [TW-1:0]      wait_reg, wait_next;
    logic               ov_reg, ov_next;
    logic [1:0]         ost_reg, ost_next;
    logic [RW-1:0]      oid_reg, oid_next;
    logic [TW-1:0]      owait_reg, owait_next;

    logic [CW-1:0]      k_dec;
    logic [CW-1:0]      k_inc;
    logic [ID_BITS-1:0] last_inc;
    logic [ID_BITS-1:0] cand_inc;
    logic [CMPW-1:0]    cand_w;
    logic [CMPW-1:0]    ent_id_w;
    logic [CMPW-1:0]    rid_w;
    logic [TW-1:0]      rem32;

    assign ent_id    = rd_data_reg[EW-1 -: ID_BITS];
    assign ent_to    = rd_data_reg[NW +: TW];
    assign ent_start = rd_data_reg[NW-1:0];
    assign k_dec     = k_reg - CW'(1);
    assign k_inc     = k_reg + CW'(1);
    assign last_inc  = last_reg + ID_BITS'(1);
    assign cand_inc  = cand_reg + ID_BITS'(1);
    assign cand_w    = CMPW'(cand_reg);
    assign ent_id_w  = CMPW'(ent_id);
    assign rid_w     = CMPW'(rid_reg);
    assign rem32     = t_reg - el_reg[TW-1:0];

    assign req.ready     = (state_reg == ott_pkg::S_IDLE);
    assign rsp.valid     = ov_reg;
    assign rsp.status    = ost_reg;
    assign rsp.timer_id  = oid_reg;
    assign rsp.wait_ms   = owait_reg;

    // Memory read and write ports.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Controller: next state, scan indexes and response.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        last_next  = last_reg;
        k_next     = k_reg;
        pos_next   = pos_reg;
        cand_next  = cand_reg;
        tries_next = tries_reg;
        el_next    = el_reg;
        t_next     = t_reg;
        now_next   = now_reg;
        to_next    = to_reg;
        rid_next   = rid_reg;
        st_next    = st_reg;
        id_next    = id_reg;
        wait_next  = wait_reg;
        ov_next    = ov_reg & ~rsp.ready;
        ost_next   = ost_reg;
        oid_next   = oid_reg;
        owait_next = owait_reg;
        rd_addr    = k_reg[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = k_reg[AW-1:0];
        wr_data    = rd_data_reg;

        unique case (state_reg)
            ott_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    now_next  = req.now_ms;
                    to_next   = req.timeout_ms;
                    rid_next  = req.request_id;
                    st_next   = ott_pkg::ST_NOT_FOUND;
                    id_next   = '0;
                    wait_next = '0;
                    k_next    = '0;
                    unique case (ott_pkg::op_t'(req.operation))
                        ott_pkg::OP_REGISTER:
                        begin
                            if (count_reg >= MAX_CNT)
                            begin
                                st_next    = ott_pkg::ST_FULL;
                                state_next = ott_pkg::S_DONE;
                            end
                            else
                            begin
                                last_next  = last_inc & ID_MASK;
                                cand_next  = (last_inc == '0) ? ID_BITS'(1) : last_inc;
                                tries_next = '0;
                                state_next = ott_pkg::S_ID_RD;
                            end
                        end
                        ott_pkg::OP_UNREGISTER: state_next = ott_pkg::S_UNR_RD;
                        ott_pkg::OP_NEXT_WAIT:  state_next = ott_pkg::S_NW_RD;
                        ott_pkg::OP_TAKE_EXP:   state_next = ott_pkg::S_EXP_RD;
                        default:                state_next = ott_pkg::S_DONE;
                    endcase
                end
            end

            // Id search: one pass per candidate, cut short where the candidate is in use.
            ott_pkg::S_ID_RD:
            begin
                if (k_reg == count_reg)
                begin
                    k_next     = '0;
                    pos_next   = count_reg;
                    state_next = ott_pkg::S_POS_RD;
                end
                else
                begin
                    state_next = ott_pkg::S_ID_CHK;
                end
            end
            ott_pkg::S_ID_CHK:
            begin
                if (ent_id == cand_reg)
                begin
                    if (tries_reg + ID_BITS'(1) == ID_MASK)
                    begin
                        st_next    = ott_pkg::ST_NO_ID;
                        state_next = ott_pkg::S_DONE;
                    end
                    else
                    begin
                        tries_next = tries_reg + ID_BITS'(1);
                        cand_next  = (cand_inc == '0) ? ID_BITS'(1) : cand_inc;
                        k_next     = '0;
                        state_next = ott_pkg::S_ID_RD;
                    end
                end
                else
                begin
                    k_next     = k_inc;
                    state_next = ott_pkg::S_ID_RD;
                end
            end

            // Insert point: first entry with more time left than the new timeout.
            ott_pkg::S_POS_RD:
            begin
                if (k_reg == count_reg)
                begin
                    state_next = ott_pkg::S_INS_RD;
                    k_next     = count_reg;
                end
                else
                begin
                    state_next = ott_pkg::S_POS_DAT;
                end
            end
            ott_pkg::S_POS_DAT:
            begin
                el_next    = now_reg - ent_start;
                t_next     = ent_to;
                state_next = ott_pkg::S_POS_EVAL;
            end
            ott_pkg::S_POS_EVAL:
            begin
                if ((el_reg <= NW'(t_reg)) && (rem32 > to_reg))
                begin
                    pos_next   = k_reg;
                    k_next     = count_reg;
                    state_next = ott_pkg::S_INS_RD;
                end
                else
                begin
                    k_next     = k_inc;
                    state_next = ott_pkg::S_POS_RD;
                end
            end

            // Shift the tail down by one, then place the new entry.
            ott_pkg::S_INS_RD:
            begin
                rd_addr = k_dec[AW-1:0];
                if (k_reg == pos_reg)
                begin
                    state_next = ott_pkg::S_INS_PUT;
                end
                else
                begin
                    state_next = ott_pkg::S_INS_WR;
                end
            end
            ott_pkg::S_INS_WR:
            begin
                wr_en      = 1'b1;
                k_next     = k_dec;
                state_next = ott_pkg::S_INS_RD;
            end
            ott_pkg::S_INS_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg[AW-1:0];
                wr_data    = {cand_reg, to_reg, now_reg};
                count_next = count_reg + CW'(1);
                last_next  = cand_reg;
                st_next    = ott_pkg::ST_OK;
                id_next    = cand_w[RW-1:0];
                state_next = ott_pkg::S_DONE;
            end

            // Unregister: find the id.
            ott_pkg::S_UNR_RD:
            begin
                if (k_reg == count_reg)
                begin
                    state_next = ott_pkg::S_DONE;
                end
                else
                begin
                    state_next = ott_pkg::S_UNR_CHK;
                end
            end
            ott_pkg::S_UNR_CHK:
            begin
                if (ent_id_w == rid_w)
                begin
                    st_next    = ott_pkg::ST_OK;
                    state_next = ott_pkg::S_DEL_RD;
                end
                else
                begin
                    k_next     = k_inc;
                    state_next = ott_pkg::S_UNR_RD;
                end
            end

            // Remove entry k by shifting the tail up by one.
            ott_pkg::S_DEL_RD:
            begin
                rd_addr = k_inc[AW-1:0];
                if (k_inc >= count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ott_pkg::S_DONE;
                end
                else
                begin
                    state_next = ott_pkg::S_DEL_WR;
                end
            end
            ott_pkg::S_DEL_WR:
            begin
                wr_en      = 1'b1;
                k_next     = k_inc;
                state_next = ott_pkg::S_DEL_RD;
            end

            // Next wait: clamp future starts, report the head.
            ott_pkg::S_NW_RD:
            begin
                if (k_reg == count_reg)
                begin
                    state_next = ott_pkg::S_DONE;
                end
                else
                begin
                    state_next = ott_pkg::S_NW_DAT;
                end
            end
            ott_pkg::S_NW_DAT:
            begin
                if (ent_start > now_reg)
                begin
                    wr_en   = 1'b1;
                    wr_data = {ent_id, ent_to, now_reg};
                    el_next = '0;
                end
                else
                begin
                    el_next = now_reg - ent_start;
                end
                t_next = ent_to;
                if (k_reg == '0)
                begin
                    state_next = ott_pkg::S_NW_EVAL;
                end
                else
                begin
                    k_next     = k_inc;
                    state_next = ott_pkg::S_NW_RD;
                end
            end
            ott_pkg::S_NW_EVAL:
            begin
                st_next    = ott_pkg::ST_OK;
                wait_next  = (el_reg <= NW'(t_reg)) ? rem32 : '0;
                k_next     = k_inc;
                state_next = ott_pkg::S_NW_RD;
            end

            // Take expired: first entry with no time left.
            ott_pkg::S_EXP_RD:
            begin
                if (k_reg == count_reg)
                begin
                    state_next = ott_pkg::S_DONE;
                end
                else
                begin
                    state_next = ott_pkg::S_EXP_DAT;
                end
            end
            ott_pkg::S_EXP_DAT:
            begin
                el_next    = now_reg - ent_start;
                t_next     = ent_to;
                cand_next  = ent_id;
                state_next = ott_pkg::S_EXP_EVAL;
            end
            ott_pkg::S_EXP_EVAL:
            begin
                if (el_reg >= NW'(t_reg))
                begin
                    st_next    = ott_pkg::ST_OK;
                    id_next    = cand_w[RW-1:0];
                    state_next = ott_pkg::S_DEL_RD;
                end
                else
                begin
                    k_next     = k_inc;
                    state_next = ott_pkg::S_EXP_RD;
                end
            end

            // Hand the result to the output register once it is free.
            ott_pkg::S_DONE:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next    = 1'b1;
                    ost_next   = st_reg;
                    oid_next   = id_reg;
                    owait_next = wait_reg;
                    state_next = ott_pkg::S_IDLE;
                end
            end

            default: state_next = ott_pkg::S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ott_pkg::S_IDLE;
            count_reg <= '0;
            last_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            last_reg  <= last_next;
            ov_reg    <= ov_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        pos_reg   <= pos_next;
        cand_reg  <= cand_next;
        tries_reg <= tries_next;
        el_reg    <= el_next;
        t_reg     <= t_next;
        now_reg   <= now_next;
        to_reg    <= to_next;
        rid_reg   <= rid_next;
        st_reg    <= st_next;
        id_reg    <= id_next;
        wait_reg  <= wait_next;
        ost_reg   <= ost_next;
        oid_reg   <= oid_next;
        owait_reg <= owait_next;
    end

endmodule

@@ design/ott_checker.sv @@
// ----------------------------------------------------------------------------
// Ordered timer table checker
// Port-level properties of the timer table, bound to its top level.
// ----------------------------------------------------------------------------
module ott_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [1:0]  status,
    input logic [15:0] timer_id,
    input logic [31:0] wait_ms
);

    // A stalled response beat holds its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable({status, timer_id, wait_ms}))
        else $error("response changed while stalled");

    // The table works on one request at a time.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // A failed request carries no id.
    a_fail_id: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ott_pkg::ST_OK) |-> timer_id == 16'd0)
        else $error("failure carries an id");

    // A failed request carries no wait time.
    a_fail_wait: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ott_pkg::ST_OK) |-> wait_ms == 32'd0)
        else $error("failure carries a wait time");

endmodule

bind ordered_timer_table ott_checker u_ott_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (rsp.status),
    .timer_id  (rsp.timer_id),
    .wait_ms   (rsp.wait_ms)
);

@@ verif/ordered_timer_table_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ordered timer table testbench
// A directed table walks empty-table answers, extreme times and timeouts,
// future start times and unknown ids. A random mix of register, unregister,
// next-wait and take-expired requests follows, and the run ends by filling
// the table to its limit. Every response beat is compared with a behavioral
// copy of the table kept in this file, under random stalls on both channels.
// ----------------------------------------------------------------------------
module ordered_timer_table_tb;

    localparam int unsigned TABLE_DEPTH = 512;
    localparam int unsigned CYCLE_LIMIT = 4000000;
    localparam int unsigned RANDOM_ITEMS = 40;

    typedef struct {
        logic [15:0] id;
        logic [31:0] timeout;
        logic [63:0] start;
    } timer_entry_t;

    typedef struct {
        ott_pkg::status_t status;
        logic [15:0]      timer_id;
        logic [31:0]      wait_ms;
    } answer_t;

    typedef struct {
        ott_pkg::op_t op;
        logic [63:0]  now;
        logic [31:0]  timeout;
        logic [15:0]  rid;
        bit           typed;
        answer_t      answer;
    } stim_row_t;

    logic clk;
    logic rst_n;

    ott_req_if req ();
    ott_rsp_if rsp ();

    ordered_timer_table uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Behavioral copy of the table.
    timer_entry_t timers[$];
    logic [15:0]  last_issued;

    // Answers still owed by the block, oldest first.
    answer_t      pending_answers[$];

    int unsigned  error_count;
    int unsigned  cycle_count;
    bit           quiet;
    int unsigned  rsp_hold;

    always #4 clk = ~clk;

    // Remaining time of one timer, with elapsed time taken modulo 2^64.
    function automatic logic [63:0] time_left(timer_entry_t t, logic [63:0] now);
        logic [63:0] elapsed;
        elapsed = now - t.start;
        return ({32'd0, t.timeout} >= elapsed) ? ({32'd0, t.timeout} - elapsed) : 64'd0;
    endfunction

    function automatic bit id_live(logic [15:0] id);
        foreach (timers[k])
            if (timers[k].id == id)
                return 1'b1;
        return 1'b0;
    endfunction

    // Apply one request to the table copy and return the answer it earns.
    function automatic answer_t apply_request(ott_pkg::op_t op, logic [63:0] now,
                                              logic [31:0] timeout, logic [15:0] rid);
        answer_t      a;
        timer_entry_t t;
        logic [15:0]  cand;
        int           pos;
        bit           found;
        a = '{ott_pkg::ST_NOT_FOUND, 16'd0, 32'd0};
        case (op)
            ott_pkg::OP_REGISTER:
            begin
                if (timers.size() >= TABLE_DEPTH)
                begin
                    a.status = ott_pkg::ST_FULL;
                    return a;
                end
                last_issued = last_issued + 16'd1;
                cand = (last_issued == 16'd0) ? 16'd1 : last_issued;
                found = 1'b0;
                for (int n = 0; n < 65535; n++)
                begin
                    if (!id_live(cand))
                    begin
                        found = 1'b1;
                        break;
                    end
                    cand = cand + 16'd1;
                    if (cand == 16'd0)
                        cand = 16'd1;
                end
                if (!found)
                begin
                    a.status = ott_pkg::ST_NO_ID;
                    return a;
                end
                pos = timers.size();
                foreach (timers[k])
                    if (time_left(timers[k], now) > {32'd0, timeout})
                    begin
                        pos = k;
                        break;
                    end
                t = '{cand, timeout, now};
                timers.insert(pos, t);
                last_issued = cand;
                a.status = ott_pkg::ST_OK;
                a.timer_id = cand;
            end
            ott_pkg::OP_UNREGISTER:
            begin
                foreach (timers[k])
                    if (timers[k].id == rid)
                    begin
                        timers.delete(k);
                        a.status = ott_pkg::ST_OK;
                        break;
                    end
            end
            ott_pkg::OP_NEXT_WAIT:
            begin
                // Start times in the future are pulled back to now first.
                foreach (timers[k])
                    if (timers[k].start > now)
                        timers[k].start = now;
                if (timers.size() > 0)
                begin
                    a.status = ott_pkg::ST_OK;
                    a.wait_ms = time_left(timers[0], now);
                end
            end
            default:
            begin
                foreach (timers[k])
                    if (time_left(timers[k], now) == 64'd0)
                    begin
                        a.status = ott_pkg::ST_OK;
                        a.timer_id = timers[k].id;
                        timers.delete(k);
                        break;
                    end
            end
        endcase
        return a;
    endfunction

    // Send one request beat; the answer is worked out once the beat is taken.
    task automatic send_request(ott_pkg::op_t op, logic [63:0] now, logic [31:0] timeout,
                                logic [15:0] rid, bit typed, answer_t typed_answer);
        int unsigned gap;
        answer_t     a;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.operation  <= op;
        req.now_ms     <= now;
        req.timeout_ms <= timeout;
        req.request_id <= rid;
        do
            @(posedge clk);
        while (!req.ready);
        a = apply_request(op, now, timeout, rid);
        pending_answers.push_back(typed ? typed_answer : a);
    endtask

    // Response side: a random stall is drawn after every beat.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            rsp_hold  <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                automatic int unsigned h = quiet ? 0 : $urandom_range(0, 11);
                rsp_hold  <= h;
                rsp.ready <= (h == 0);
            end
            else if (rsp_hold > 0)
            begin
                rsp_hold  <= rsp_hold - 1;
                rsp.ready <= (rsp_hold == 1);
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // Compare every response beat with the oldest owed answer.
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("response beat with no request outstanding");
                error_count++;
            end
            else
            begin
                automatic answer_t e = pending_answers.pop_front();
                if (rsp.status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, rsp.status);
                    error_count++;
                end
                if (rsp.timer_id !== e.timer_id)
                begin
                    $error("timer_id: expected %0d, got %0d", e.timer_id, rsp.timer_id);
                    error_count++;
                end
                if (rsp.wait_ms !== e.wait_ms)
                begin
                    $error("wait_ms: expected %0d, got %0d", e.wait_ms, rsp.wait_ms);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        stim_row_t    rows[$];
        logic [63:0]  clock_ms;
        logic [63:0]  now;
        logic [31:0]  timeout;
        logic [15:0]  rid;
        int unsigned  pick;
        ott_pkg::op_t op;
        answer_t      none;

        clk            = 1'b0;
        rst_n          = 1'b0;
        req.valid      = 1'b0;
        req.operation  = ott_pkg::OP_NEXT_WAIT;
        req.now_ms     = 64'd0;
        req.timeout_ms = 32'd0;
        req.request_id = 16'd0;
        error_count    = 0;
        cycle_count    = 0;
        quiet          = 1'b0;
        last_issued    = 16'd0;
        none           = '{ott_pkg::ST_NOT_FOUND, 16'd0, 32'd0};

        // Empty table, first ids, extreme times and timeouts, future starts.
        rows.push_back('{ott_pkg::OP_NEXT_WAIT, 64'd0, 32'd0, 16'd0, 1'b1, none});
        rows.push_back('{ott_pkg::OP_TAKE_EXP, '1, '1, 16'd0, 1'b1, none});
        rows.push_back('{ott_pkg::OP_UNREGISTER, 64'd0, 32'd0, 16'hFFFF, 1'b1, none});
        rows.push_back('{ott_pkg::OP_REGISTER, 64'd100, 32'd0, 16'd0, 1'b1,
                         '{ott_pkg::ST_OK, 16'd1, 32'd0}});
        rows.push_back('{ott_pkg::OP_REGISTER, 64'd100, '1, 16'd0, 1'b1,
                         '{ott_pkg::ST_OK, 16'd2, 32'd0}});
        rows.push_back('{ott_pkg::OP_REGISTER, 64'd200, 32'd50, 16'd0, 1'b0, none});
        rows.push_back('{ott_pkg::OP_NEXT_WAIT, 64'd150, 32'd0, 16'd0, 1'b0, none});
        rows.push_back('{ott_pkg::OP_TAKE_EXP, 64'd150, 32'd0, 16'd0, 1'b0, none});
        rows.push_back('{ott_pkg::OP_REGISTER, 64'd5000, 32'd100, 16'd0, 1'b0, none});
        rows.push_back('{ott_pkg::OP_TAKE_EXP, 64'd3000, 32'd0, 16'd0, 1'b0, none});
        rows.push_back('{ott_pkg::OP_REGISTER, 64'd9000, 32'd100, 16'd0, 1'b0, none});
        rows.push_back('{ott_pkg::OP_NEXT_WAIT, 64'd4000, 32'd0, 16'd0, 1'b0, none});
        rows.push_back('{ott_pkg::OP_NEXT_WAIT, 64'd4040, 32'd0, 16'd0, 1'b0, none});
        rows.push_back('{ott_pkg::OP_UNREGISTER, 64'd4040, 32'd0, 16'd2, 1'b0, none});
        rows.push_back('{ott_pkg::OP_UNREGISTER, 64'd4040, 32'd0, 16'd2, 1'b0, none});
        rows.push_back('{ott_pkg::OP_REGISTER, '1, 32'd5, 16'hFFFF, 1'b0, none});
        rows.push_back('{ott_pkg::OP_REGISTER, '1, '1, 16'd0, 1'b0, none});
        rows.push_back('{ott_pkg::OP_NEXT_WAIT, '1, 32'd0, 16'd0, 1'b0, none});
        rows.push_back('{ott_pkg::OP_TAKE_EXP, 64'd0, 32'd0, 16'd0, 1'b0, none});
        rows.push_back('{ott_pkg::OP_TAKE_EXP, 64'd4200, 32'd0, 16'd0, 1'b0, none});
        rows.push_back('{ott_pkg::OP_TAKE_EXP, '1, 32'd0, 16'd0, 1'b0, none});
        rows.push_back('{ott_pkg::OP_NEXT_WAIT, 64'd0, 32'd0, 16'd0, 1'b0, none});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_request(rows[i].op, rows[i].now, rows[i].timeout, rows[i].rid,
                         rows[i].typed, rows[i].answer);

        // Random mix; the table is kept small so that each request stays short.
        clock_ms = 64'd10000;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 100 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            clock_ms = clock_ms + $urandom_range(0, 300);
            now = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom} : clock_ms;
            timeout = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 2000);
            pick = $urandom_range(0, 99);
            if (timers.size() > 40)
                pick = pick % 65 + 35;
            if (pick < 35)
                op = ott_pkg::OP_REGISTER;
            else if (pick < 55)
                op = ott_pkg::OP_UNREGISTER;
            else if (pick < 75)
                op = ott_pkg::OP_NEXT_WAIT;
            else
                op = ott_pkg::OP_TAKE_EXP;
            if (timers.size() > 0 && $urandom_range(0, 4) != 0)
                rid = timers[$urandom_range(0, timers.size() - 1)].id;
            else
                rid = $urandom_range(0, 65535);
            send_request(op, now, timeout, rid, 1'b0, none);
        end

        // Fill the table to its limit with late timers, then hit the full case.
        quiet = 1'b1;
        while (timers.size() < TABLE_DEPTH)
            send_request(ott_pkg::OP_REGISTER, clock_ms, '1, 16'd0, 1'b0, none);
        quiet = 1'b0;
        send_request(ott_pkg::OP_REGISTER, clock_ms, 32'd0, 16'd0, 1'b0, none);
        send_request(ott_pkg::OP_REGISTER, '1, '1, 16'd0, 1'b0, none);

        req.valid <= 1'b0;
        while (pending_answers.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ filelist.f @@
design/ott_pkg.sv
design/ott_if.sv
design/ordered_timer_table.sv
design/ott_checker.sv
verif/ordered_timer_table_tb.sv
